FILE: rtl/tone_curve_blend_pixel_core_macros.svh
// Assertion macros for the checker file of the tone curve block.
`ifndef TONE_CURVE_BLEND_PIXEL_CORE_MACROS_SVH
`define TONE_CURVE_BLEND_PIXEL_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define TCB_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define TCB_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/tcb_pkg.sv
// Types, codes and arithmetic helpers for the tone curve blend pixel core.
package tcb_pkg;

	localparam int unsigned CURVE_ENTRIES = 256;
	localparam int unsigned PIX_W         = 8;
	localparam int unsigned NUM_CH        = 3;
	localparam logic [7:0]  FULL_SCALE    = 8'd255;

	typedef enum logic [1:0] {
		TBL_SHADOWS    = 2'd0,
		TBL_HIGHLIGHTS = 2'd1,
		TBL_MIDTONE    = 2'd2
	} tcb_table_e;

	typedef enum logic [1:0] {
		REG_SHADOWS_EN    = 2'd0,
		REG_HIGHLIGHTS_EN = 2'd1,
		REG_MIDTONE_EN    = 2'd2
	} tcb_reg_e;

	typedef enum logic {
		OP_PIXEL = 1'b0,
		OP_LOAD  = 1'b1
	} tcb_op_e;

	// One beat as it travels down the stage chain.
	typedef struct packed {
		logic                             load;
		logic [1:0]                       sel;
		logic [PIX_W-1:0]                 idx;
		logic [PIX_W-1:0]                 val;
		logic [NUM_CH-1:0][PIX_W-1:0]     ch;
	} tcb_beat_t;

	// floor(x / 255) for x <= 255*255, no divider needed.
	function automatic logic [7:0] div255(input logic [15:0] x);
		logic [16:0] y;
		y = {1'b0, x} + {9'd0, x[15:8]} + 17'd1;
		return y[15:8];
	endfunction

endpackage

FILE: rtl/tcb_ram.sv
// Generic single-write, single-read RAM with registered read data.
module tcb_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: rtl/tcb_curve_stage.sv
// One tone curve stage: table lookup per channel, blend product, divide by 255 if enabled.
module tcb_curve_stage #(
	parameter tcb_pkg::tcb_table_e TABLE_ID = tcb_pkg::TBL_SHADOWS
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              adv,
	input  logic              enable,
	input  logic              in_valid,
	input  tcb_pkg::tcb_beat_t in_beat,
	output logic              out_valid,
	output tcb_pkg::tcb_beat_t out_beat
);

	localparam bit DARK = (TABLE_ID != tcb_pkg::TBL_HIGHLIGHTS);

	logic                                          we;
	logic [tcb_pkg::NUM_CH-1:0][tcb_pkg::PIX_W-1:0] tval;
	logic [tcb_pkg::NUM_CH-1:0][15:0]              sum;

	logic              valid_s1;
	tcb_pkg::tcb_beat_t beat_s1;
	logic              valid_s2;
	tcb_pkg::tcb_beat_t beat_s2;
	logic [tcb_pkg::NUM_CH-1:0][15:0] sum_s2;

	// Loads for this table land here, in beat order with pixel reads.
	assign we = adv && in_valid && (in_beat.load == tcb_pkg::OP_LOAD)
		&& (in_beat.sel == TABLE_ID);

	for (genvar n = 0; n < tcb_pkg::NUM_CH; n++) begin : g_ram
		tcb_ram #(
			.WIDTH(tcb_pkg::PIX_W),
			.DEPTH(tcb_pkg::CURVE_ENTRIES)
		) u_ram (
			.clk  (clk),
			.we   (we),
			.waddr(in_beat.idx),
			.wdata(in_beat.val),
			.re   (adv),
			.raddr(in_beat.ch[n]),
			.rdata(tval[n])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
		end
	end

	always_comb begin
		logic [7:0]  c;
		logic [7:0]  inv;
		logic [15:0] p_t;
		logic [15:0] p_c;
		for (int n = 0; n < tcb_pkg::NUM_CH; n++) begin
			c   = beat_s1.ch[n];
			inv = tcb_pkg::FULL_SCALE - c;
			if (DARK) begin
				p_t = {8'd0, tval[n]} * {8'd0, inv};
				p_c = {8'd0, c} * {8'd0, c};
			end else begin
				p_t = {8'd0, tval[n]} * {8'd0, c};
				p_c = {8'd0, c} * {8'd0, inv};
			end
			sum[n] = p_t + p_c;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			beat_s1 <= in_beat;
			beat_s2 <= beat_s1;
			sum_s2  <= sum;
		end
	end

	always_comb begin
		out_beat = beat_s2;
		if (enable) begin
			for (int n = 0; n < tcb_pkg::NUM_CH; n++) begin
				out_beat.ch[n] = tcb_pkg::div255(sum_s2[n]);
			end
		end
	end

	assign out_valid = valid_s2;

endmodule

FILE: rtl/tone_curve_blend_pixel_core.sv
// Tone curve blend pixel core: three chained curve stages over replicated table RAMs.
// Throughput: one beat (pixel or table load) per cycle; the chain moves as one and
// stalls only while the output register holds a beat not yet taken.
// Pipeline: the accepting edge loads the first of two registers per curve stage
// (table RAM read, blend product); the last curve stage feeds the output register.
// Reset: arst_n clears the enables and all valid flags; table contents stay undefined.
module tone_curve_blend_pixel_core (
	input  logic        clk,
	input  logic        arst_n,
	// configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// input channel
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        operation,
	input  logic [1:0]  table_select,
	input  logic [7:0]  table_index,
	input  logic [7:0]  table_value,
	input  logic [7:0]  channel_0_in,
	input  logic [7:0]  channel_1_in,
	input  logic [7:0]  channel_2_in,
	// output channel
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  channel_0_out,
	output logic [7:0]  channel_1_out,
	output logic [7:0]  channel_2_out
);

	logic shadows_en_q;
	logic highlights_en_q;
	logic midtone_en_q;
	logic cfg_wr;
	logic adv;

	tcb_pkg::tcb_beat_t in_beat;
	logic               v0;
	logic               v1;
	logic               v2;
	tcb_pkg::tcb_beat_t b0;
	tcb_pkg::tcb_beat_t b1;
	tcb_pkg::tcb_beat_t b2;

	logic       out_valid_q;
	logic [7:0] ch0_q;
	logic [7:0] ch1_q;
	logic [7:0] ch2_q;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shadows_en_q    <= 1'b0;
			highlights_en_q <= 1'b0;
			midtone_en_q    <= 1'b0;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				tcb_pkg::REG_SHADOWS_EN:    shadows_en_q    <= pwdata[0];
				tcb_pkg::REG_HIGHLIGHTS_EN: highlights_en_q <= pwdata[0];
				tcb_pkg::REG_MIDTONE_EN:    midtone_en_q    <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			tcb_pkg::REG_SHADOWS_EN:    prdata = {31'd0, shadows_en_q};
			tcb_pkg::REG_HIGHLIGHTS_EN: prdata = {31'd0, highlights_en_q};
			tcb_pkg::REG_MIDTONE_EN:    prdata = {31'd0, midtone_en_q};
			default:                    prdata = 32'd0;
		endcase
	end

	// Whole chain advances unless a finished pixel is stuck in the output register.
	assign adv      = !out_valid_q || out_ready;
	assign in_ready = adv;

	always_comb begin
		in_beat.load  = operation;
		in_beat.sel   = table_select;
		in_beat.idx   = table_index;
		in_beat.val   = table_value;
		in_beat.ch[0] = channel_0_in;
		in_beat.ch[1] = channel_1_in;
		in_beat.ch[2] = channel_2_in;
	end

	tcb_curve_stage #(.TABLE_ID(tcb_pkg::TBL_SHADOWS)) u_shadows (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.enable   (shadows_en_q),
		.in_valid (in_valid),
		.in_beat  (in_beat),
		.out_valid(v0),
		.out_beat (b0)
	);

	tcb_curve_stage #(.TABLE_ID(tcb_pkg::TBL_HIGHLIGHTS)) u_highlights (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.enable   (highlights_en_q),
		.in_valid (v0),
		.in_beat  (b0),
		.out_valid(v1),
		.out_beat (b1)
	);

	tcb_curve_stage #(.TABLE_ID(tcb_pkg::TBL_MIDTONE)) u_midtone (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.enable   (midtone_en_q),
		.in_valid (v1),
		.in_beat  (b1),
		.out_valid(v2),
		.out_beat (b2)
	);

	// Load beats end here; only pixels reach the output.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= v2 && (b2.load == tcb_pkg::OP_PIXEL);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ch0_q <= b2.ch[0];
			ch1_q <= b2.ch[1];
			ch2_q <= b2.ch[2];
		end
	end

	assign out_valid     = out_valid_q;
	assign channel_0_out = ch0_q;
	assign channel_1_out = ch1_q;
	assign channel_2_out = ch2_q;

endmodule

FILE: rtl/tcb_checker.sv
// Port-level checker for the tone curve blend pixel core, bound to the top level.
`include "tone_curve_blend_pixel_core_macros.svh"

module tcb_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       pready,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] channel_0_out,
	input logic [7:0] channel_1_out,
	input logic [7:0] channel_2_out
);

	logic        out_stall;
	logic [23:0] out_data;

	assign out_stall = out_valid && !out_ready;
	assign out_data  = {channel_2_out, channel_1_out, channel_0_out};

	`TCB_ASSERT_NEXT(a_out_hold, out_stall, out_valid, "output beat dropped under stall")
	`TCB_ASSERT_NEXT(a_out_stable, out_stall, $stable(out_data), "output payload moved under stall")
	`TCB_ASSERT_NOW(a_stall_blocks_in, out_stall, !in_ready, "input taken while output stalled")
	`TCB_ASSERT_NOW(a_free_takes_in, !out_stall, in_ready, "input refused with free output")
	`TCB_ASSERT_NOW(a_pready_high, in_valid || !in_valid, pready, "pready dropped")

endmodule

bind tone_curve_blend_pixel_core tcb_checker u_tcb_checker (.*);

FILE: dv/tb_tone_curve_blend_pixel_core.sv
// Self-checking testbench for the tone curve blend pixel core.
`timescale 1ns / 1ps

module tb_tone_curve_blend_pixel_core;

	localparam int unsigned LIMIT_CYCLES = 400000;
	localparam int unsigned SETTLE_CYCLES = 16;
	localparam int unsigned ITEMS_PER_SETTING = 52;
	// Mid window of written table entries, beside entries 0 and 255.
	localparam int unsigned LVL_LO = 96;
	localparam int unsigned LVL_HI = 159;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [3:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic        operation = tcb_pkg::OP_PIXEL;
	logic [1:0]  table_select = '0;
	logic [7:0]  table_index = '0;
	logic [7:0]  table_value = '0;
	logic [7:0]  channel_0_in = '0;
	logic [7:0]  channel_1_in = '0;
	logic [7:0]  channel_2_in = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [7:0]  channel_0_out;
	logic [7:0]  channel_1_out;
	logic [7:0]  channel_2_out;

	tone_curve_blend_pixel_core dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.operation     (operation),
		.table_select  (table_select),
		.table_index   (table_index),
		.table_value   (table_value),
		.channel_0_in  (channel_0_in),
		.channel_1_in  (channel_1_in),
		.channel_2_in  (channel_2_in),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.channel_0_out (channel_0_out),
		.channel_1_out (channel_1_out),
		.channel_2_out (channel_2_out)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Shadow copy of the curve tables and the stage enables.
	logic [7:0] curve_lut [0:2][0:255];
	logic       shadows_on = 1'b0;
	logic       highlights_on = 1'b0;
	logic       midtone_on = 1'b0;

	logic [2:0][7:0] toned_pixel_q [$];
	int unsigned     mismatches = 0;
	int unsigned     cycles = 0;
	int unsigned     burst_left = 0;

	function automatic logic [7:0] blend_dark(input logic [7:0] t, input logic [7:0] c);
		int unsigned tv;
		int unsigned cv;
		int unsigned x;
		tv = t;
		cv = c;
		x = (tv * (255 - cv) + cv * cv) / 255;
		return x[7:0];
	endfunction

	function automatic logic [7:0] blend_bright(input logic [7:0] t, input logic [7:0] c);
		int unsigned tv;
		int unsigned cv;
		int unsigned x;
		tv = t;
		cv = c;
		x = (tv * cv + cv * (255 - cv)) / 255;
		return x[7:0];
	endfunction

	function automatic logic [7:0] tone_channel(input logic [7:0] c);
		logic [7:0] v;
		v = c;
		if (shadows_on)
			v = blend_dark(curve_lut[tcb_pkg::TBL_SHADOWS][v], v);
		if (highlights_on)
			v = blend_bright(curve_lut[tcb_pkg::TBL_HIGHLIGHTS][v], v);
		if (midtone_on)
			v = blend_dark(curve_lut[tcb_pkg::TBL_MIDTONE][v], v);
		return v;
	endfunction

	// Channel level with the extremes weighted up.
	function automatic logic [7:0] rand_level();
		int unsigned r;
		r = $urandom_range(0, 9);
		if (r == 0)
			return 8'd0;
		if (r == 1)
			return 8'd255;
		return 8'($urandom_range(LVL_LO, LVL_HI));
	endfunction

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT_CYCLES) begin
			$display("timeout after %0d cycles, %0d results outstanding",
				cycles, toned_pixel_q.size());
			$display("*** FAILED ***");
			$finish;
		end
	end

	// Receiver: phases of always-ready, random, sparse, and ready then stalled.
	int unsigned rx_mode = 0;
	int unsigned rx_left = 0;
	int unsigned rx_tick = 0;
	always @(posedge clk) begin
		rx_tick <= rx_tick + 1;
		if (rx_left == 0) begin
			rx_mode <= $urandom_range(0, 3);
			rx_left <= $urandom_range(1, 40);
		end else begin
			rx_left <= rx_left - 1;
		end
		case (rx_mode)
			0: out_ready <= 1'b1;
			1: out_ready <= $urandom_range(0, 1);
			2: out_ready <= (rx_tick % 4 == 0);
			default: out_ready <= (rx_left > 12);
		endcase
	end

	always @(posedge clk) begin
		logic [2:0][7:0] want;
		if (arst_n && out_valid && out_ready) begin
			if (toned_pixel_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected beat: %0d %0d %0d",
						channel_0_out, channel_1_out, channel_2_out);
			end else begin
				want = toned_pixel_q.pop_front();
				if (channel_0_out !== want[0] || channel_1_out !== want[1] ||
						channel_2_out !== want[2]) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected %0d %0d %0d, got %0d %0d %0d",
							want[0], want[1], want[2],
							channel_0_out, channel_1_out, channel_2_out);
				end
			end
		end
	end

	// Drive one beat and hold it until accepted; the sender runs in bursts.
	task automatic send_beat(input tcb_pkg::tcb_op_e op, input logic [1:0] sel,
			input logic [7:0] idx, input logic [7:0] val,
			input logic [7:0] c0, input logic [7:0] c1, input logic [7:0] c2);
		int unsigned gap;
		logic [2:0][7:0] toned;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = ($urandom_range(0, 7) == 0) ? 64 : $urandom_range(1, 24);
		end
		burst_left--;
		in_valid     <= 1'b1;
		operation    <= op;
		table_select <= sel;
		table_index  <= idx;
		table_value  <= val;
		channel_0_in <= c0;
		channel_1_in <= c1;
		channel_2_in <= c2;
		do @(posedge clk); while (!in_ready);
		if (op == tcb_pkg::OP_LOAD) begin
			if (sel inside {tcb_pkg::TBL_SHADOWS, tcb_pkg::TBL_HIGHLIGHTS,
					tcb_pkg::TBL_MIDTONE})
				curve_lut[sel][idx] = val;
		end else begin
			toned[0] = tone_channel(c0);
			toned[1] = tone_channel(c1);
			toned[2] = tone_channel(c2);
			toned_pixel_q.push_back(toned);
		end
	endtask

	task automatic send_pixel(input logic [7:0] c0, input logic [7:0] c1,
			input logic [7:0] c2);
		send_beat(tcb_pkg::OP_PIXEL, 2'($urandom), 8'($urandom), 8'($urandom), c0, c1, c2);
	endtask

	task automatic send_load(input logic [1:0] sel, input logic [7:0] idx,
			input logic [7:0] val);
		send_beat(tcb_pkg::OP_LOAD, sel, idx, val, 8'($urandom), 8'($urandom), 8'($urandom));
	endtask

	// Extremes hold 0 or 255, window entries hold window values.
	task automatic send_rand_load(input logic [1:0] sel);
		logic [7:0] idx;
		logic [7:0] val;
		if ($urandom_range(0, 3) == 0) begin
			idx = $urandom_range(0, 1) ? 8'd255 : 8'd0;
			val = $urandom_range(0, 1) ? 8'd255 : 8'd0;
		end else begin
			idx = 8'($urandom_range(LVL_LO, LVL_HI));
			val = 8'($urandom_range(LVL_LO, LVL_HI));
		end
		send_load(sel, idx, val);
	endtask

	// Stop sending, wait for every pixel, then let trailing loads drain.
	task automatic wait_drained();
		in_valid <= 1'b0;
		burst_left = 0;
		while (toned_pixel_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic apb_write(input tcb_pkg::tcb_reg_e reg_id, input logic on);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {reg_id, 2'b00};
		pwdata  <= {$urandom_range(0, 1) ? 31'($urandom) : 31'd0, on};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		case (reg_id)
			tcb_pkg::REG_SHADOWS_EN:    shadows_on = on;
			tcb_pkg::REG_HIGHLIGHTS_EN: highlights_on = on;
			default:                    midtone_on = on;
		endcase
		@(posedge clk);
	endtask

	task automatic set_stages(input logic s, input logic h, input logic m);
		wait_drained();
		apb_write(tcb_pkg::REG_SHADOWS_EN, s);
		apb_write(tcb_pkg::REG_HIGHLIGHTS_EN, h);
		apb_write(tcb_pkg::REG_MIDTONE_EN, m);
		@(posedge clk);
	endtask

	// Entries 0 and 255 hold 0 or 255 and the window holds window values; a blend
	// lies between t and c, so pixels from these levels only read written entries.
	task automatic test_fill_tables();
		for (int t = 0; t < 3; t++) begin
			send_load(2'(t), 8'd0, 8'($urandom_range(0, 1) * 255));
			send_load(2'(t), 8'd255, 8'($urandom_range(0, 1) * 255));
			for (int i = LVL_LO; i <= LVL_HI; i++)
				send_load(2'(t), 8'(i), 8'($urandom_range(LVL_LO, LVL_HI)));
		end
	endtask

	task automatic test_passthrough();
		set_stages(1'b0, 1'b0, 1'b0);
		send_pixel(8'd0, 8'd0, 8'd0);
		send_pixel(8'd255, 8'd255, 8'd255);
		send_pixel(8'd0, 8'd128, 8'd255);
		send_pixel(8'd85, 8'd170, 8'd1);
	endtask

	task automatic test_load_ordering();
		set_stages(1'b1, 1'b1, 1'b1);
		send_pixel(8'd0, 8'd255, 8'd128);
		send_load(tcb_pkg::TBL_SHADOWS, 8'd0, 8'd255);
		send_load(tcb_pkg::TBL_HIGHLIGHTS, 8'd255, 8'd0);
		send_load(tcb_pkg::TBL_MIDTONE, 8'd255, 8'd255);
		// pixel right behind the loads must see the new entries
		send_pixel(8'd0, 8'd255, 8'd0);
		send_load(tcb_pkg::TBL_SHADOWS, 8'd255, 8'd0);
		send_load(tcb_pkg::TBL_HIGHLIGHTS, 8'd0, 8'd255);
		send_load(tcb_pkg::TBL_MIDTONE, 8'd0, 8'd0);
		send_pixel(8'd255, 8'd0, 8'd255);
		// select 3 writes nothing
		send_load(2'd3, 8'd0, 8'd77);
		send_load(2'd3, 8'd255, 8'd200);
		send_pixel(8'd0, 8'd255, 8'd0);
		send_pixel(8'(LVL_LO), 8'(LVL_HI), 8'd127);
	endtask

	task automatic test_single_stages();
		set_stages(1'b1, 1'b0, 1'b0);
		send_pixel(8'd0, 8'd255, 8'd100);
		set_stages(1'b0, 1'b1, 1'b0);
		send_pixel(8'd0, 8'd255, 8'd100);
		set_stages(1'b0, 1'b0, 1'b1);
		send_pixel(8'd0, 8'd255, 8'd100);
	endtask

	task automatic run_random_mix(input int unsigned count, input bit pause_midway);
		int unsigned sent;
		int unsigned r;
		sent = 0;
		while (sent < count) begin
			r = $urandom_range(0, 99);
			if (r < 22) begin
				send_rand_load(2'($urandom_range(0, 2)));
				sent++;
			end else if (r < 27) begin
				send_load(2'd3, 8'($urandom), 8'($urandom));
			end else begin
				send_pixel(rand_level(), rand_level(), rand_level());
				sent++;
			end
			if (pause_midway && sent == count / 2) begin
				wait_drained();
				pause_midway = 1'b0;
			end
		end
	endtask

	task automatic test_random_settings();
		logic [2:0] order [8];
		order = '{3'b000, 3'b111, 3'b001, 3'b110, 3'b010, 3'b101, 3'b100, 3'b011};
		foreach (order[k]) begin
			set_stages(order[k][2], order[k][1], order[k][0]);
			run_random_mix(ITEMS_PER_SETTING, k == 1);
		end
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_fill_tables();
		test_passthrough();
		test_load_ordering();
		test_single_stages();
		test_random_settings();
		wait_drained();
		if (mismatches == 0 && toned_pixel_q.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

FILE: sim.f
+incdir+rtl
rtl/tcb_pkg.sv
rtl/tcb_ram.sv
rtl/tcb_curve_stage.sv
rtl/tone_curve_blend_pixel_core.sv
rtl/tcb_checker.sv
dv/tb_tone_curve_blend_pixel_core.sv
